// ===== hdl/rms_pkg.sv =====
// ----------------------------------------------------------------------------
// rms_pkg
// Shared types and constants of the running median stream block.
// ----------------------------------------------------------------------------
package rms_pkg;

	localparam int DATA_W        = 32;
	localparam int COUNT_OUT_W   = 11;
	localparam int MAX_ITEMS_DEF = 1024;

	typedef enum logic [1:0] {
		OP_HOLD,
		OP_INSERT,
		OP_INSERT_POP,
		OP_PUSH
	} chain_op_t;

	typedef struct packed {
		chain_op_t                 op;
		logic signed [DATA_W-1:0]  value;
		logic signed [DATA_W-1:0]  push_value;
	} chain_ctrl_t;

	typedef struct packed {
		logic signed [DATA_W-1:0]  head;
		logic                      head_after;
	} chain_stat_t;

endpackage

// ===== hdl/rms_cell.sv =====
// ----------------------------------------------------------------------------
// rms_cell
// One cell of a sorted chain: holds one sample and shifts with its neighbors.
// ----------------------------------------------------------------------------
module rms_cell #(
	parameter int IDX     = 0,
	parameter int CW      = 11,
	parameter bit DESCEND = 1'b1
) (
	input  logic                              clk,
	input  rms_pkg::chain_ctrl_t              ctrl,
	input  logic [CW-1:0]                     count,
	input  logic signed [rms_pkg::DATA_W-1:0] prev_val,
	input  logic                              prev_after,
	input  logic signed [rms_pkg::DATA_W-1:0] next_val,
	input  logic                              next_after,
	output logic signed [rms_pkg::DATA_W-1:0] val_q,
	output logic                              after
);

	logic                              occupied;
	logic                              ordered;
	logic signed [rms_pkg::DATA_W-1:0] val_d;

	// The new sample goes after this cell when the cell is occupied and the
	// sample does not sort strictly ahead of the cell's value.
	assign occupied = count > CW'(IDX);
	assign ordered  = DESCEND ? (ctrl.value <= val_q) : (ctrl.value >= val_q);
	assign after    = occupied && ordered;

	always_comb begin
		unique case (ctrl.op)
			rms_pkg::OP_HOLD:       val_d = val_q;
			rms_pkg::OP_INSERT:     val_d = after ? val_q :
			                                (prev_after ? ctrl.value : prev_val);
			rms_pkg::OP_INSERT_POP: val_d = next_after ? next_val :
			                                (after ? ctrl.value : val_q);
			rms_pkg::OP_PUSH:       val_d = prev_val;
			default:                val_d = val_q;
		endcase
	end

	always_ff @(posedge clk) begin
		val_q <= val_d;
	end

endmodule

// ===== hdl/rms_chain.sv =====
// ----------------------------------------------------------------------------
// rms_chain
// A row of cells kept in sorted order; the head is the element nearest the
// median.
// ----------------------------------------------------------------------------
module rms_chain #(
	parameter int DEPTH   = 512,
	parameter int CW      = 11,
	parameter bit DESCEND = 1'b1
) (
	input  logic                 clk,
	input  rms_pkg::chain_ctrl_t ctrl,
	input  logic [CW-1:0]        count,
	output rms_pkg::chain_stat_t stat
);

	logic signed [rms_pkg::DATA_W-1:0] vals  [DEPTH];
	logic                              afters[DEPTH];

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic signed [rms_pkg::DATA_W-1:0] pv;
		logic                              pa;
		logic signed [rms_pkg::DATA_W-1:0] nv;
		logic                              na;

		if (i == 0) begin : g_first
			assign pv = ctrl.push_value;
			assign pa = 1'b1;
		end else begin : g_mid
			assign pv = vals[i-1];
			assign pa = afters[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign nv = '0;
			assign na = 1'b0;
		end else begin : g_inner
			assign nv = vals[i+1];
			assign na = afters[i+1];
		end

		rms_cell #(
			.IDX     (i),
			.CW      (CW),
			.DESCEND (DESCEND)
		) u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.count      (count),
			.prev_val   (pv),
			.prev_after (pa),
			.next_val   (nv),
			.next_after (na),
			.val_q      (vals[i]),
			.after      (afters[i])
		);
	end

	assign stat.head       = vals[0];
	assign stat.head_after = afters[0];

endmodule

// ===== hdl/rms_median.sv =====
// ----------------------------------------------------------------------------
// rms_median
// Forms the median from the heads of the lower and upper chains.
// ----------------------------------------------------------------------------
module rms_median (
	input  logic signed [rms_pkg::DATA_W-1:0] lower_head,
	input  logic signed [rms_pkg::DATA_W-1:0] upper_head,
	input  logic                              odd,
	output logic signed [rms_pkg::DATA_W-1:0] median
);

	logic signed [rms_pkg::DATA_W:0] sum;
	logic signed [rms_pkg::DATA_W:0] adj;

	// A negative sum is biased by one so that halving rounds toward zero.
	assign sum = {lower_head[rms_pkg::DATA_W-1], lower_head}
	           + {upper_head[rms_pkg::DATA_W-1], upper_head};
	assign adj = sum + {{rms_pkg::DATA_W{1'b0}}, sum[rms_pkg::DATA_W]};

	assign median = odd ? lower_head : adj[rms_pkg::DATA_W:1];

endmodule

// ===== hdl/running_median_stream.sv =====
// ----------------------------------------------------------------------------
// running_median_stream
// Running median of a stream of signed samples, held in two sorted chains
// of cells that meet at the median.
// ----------------------------------------------------------------------------
// Channel   Direction   Handshake            Payload
// input     in          in_valid, in_stall   sample_value, last_of_stream
// output    out         out_valid, out_stall median_value, item_count, store_full
//
// An item is inserted into the cell chains in the cycle it is accepted, and
// its result waits in stage 1 until the output register can take it.
// One item per cycle unless the output stalls; all chain cells insert at once.
// Reset empties the store; no clearing pass is needed.
// Input stalls only while a result waits in the output register and a second
// one is already formed behind it.
// ----------------------------------------------------------------------------
module running_median_stream #(
	parameter int MAX_ITEMS = rms_pkg::MAX_ITEMS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic signed [rms_pkg::DATA_W-1:0]      sample_value,
	input  logic                                   last_of_stream,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic signed [rms_pkg::DATA_W-1:0]      median_value,
	output logic [rms_pkg::COUNT_OUT_W-1:0]        item_count,
	output logic                                   store_full
);

	localparam int CW   = $clog2(MAX_ITEMS + 1);
	localparam int LCAP = (MAX_ITEMS + 1) / 2;
	localparam int UCAP = MAX_ITEMS / 2;

	logic [CW-1:0]                     held_q;
	logic                              valid_s1;
	logic [CW-1:0]                     count_s1;
	logic                              full_s1;
	logic                              out_valid_q;
	logic signed [rms_pkg::DATA_W-1:0] median_q;
	logic [rms_pkg::COUNT_OUT_W-1:0]   count_q;
	logic                              full_q;

	logic                              accept;
	logic                              s1_adv;
	logic                              full;
	logic                              to_lower;
	logic [CW:0]                       held_inc;
	logic [CW-1:0]                     lower_count;
	logic [CW-1:0]                     upper_count;
	rms_pkg::chain_ctrl_t              lower_ctrl;
	rms_pkg::chain_ctrl_t              upper_ctrl;
	rms_pkg::chain_stat_t              lower_stat;
	rms_pkg::chain_stat_t              upper_stat;
	logic signed [rms_pkg::DATA_W-1:0] median;
	logic [CW+rms_pkg::COUNT_OUT_W-1:0] count_ext;

	assign s1_adv   = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !s1_adv;
	assign accept   = in_valid && !in_stall;

	assign full        = held_q == CW'(MAX_ITEMS);
	assign held_inc    = {1'b0, held_q} + (CW+1)'(1);
	assign lower_count = held_inc[CW:1];
	assign upper_count = {1'b0, held_q[CW-1:1]};
	assign to_lower    = (held_q == '0) || lower_stat.head_after;

	// The lower chain holds the smaller half (one more on an odd count) in
	// descending order, the upper chain the larger half in ascending order.
	always_comb begin
		lower_ctrl.op         = rms_pkg::OP_HOLD;
		lower_ctrl.value      = sample_value;
		lower_ctrl.push_value = upper_stat.head_after ? upper_stat.head : sample_value;
		upper_ctrl.op         = rms_pkg::OP_HOLD;
		upper_ctrl.value      = sample_value;
		upper_ctrl.push_value = lower_stat.head_after ? lower_stat.head : sample_value;
		if (accept && !full) begin
			priority if (!held_q[0] && to_lower) begin
				lower_ctrl.op = rms_pkg::OP_INSERT;
			end else if (!held_q[0]) begin
				upper_ctrl.op = rms_pkg::OP_INSERT_POP;
				lower_ctrl.op = rms_pkg::OP_PUSH;
			end else if (to_lower) begin
				lower_ctrl.op = rms_pkg::OP_INSERT_POP;
				upper_ctrl.op = rms_pkg::OP_PUSH;
			end else begin
				upper_ctrl.op = rms_pkg::OP_INSERT;
			end
		end
	end

	rms_chain #(
		.DEPTH   (LCAP),
		.CW      (CW),
		.DESCEND (1'b1)
	) u_lower (
		.clk   (clk),
		.ctrl  (lower_ctrl),
		.count (lower_count),
		.stat  (lower_stat)
	);

	rms_chain #(
		.DEPTH   (UCAP),
		.CW      (CW),
		.DESCEND (1'b0)
	) u_upper (
		.clk   (clk),
		.ctrl  (upper_ctrl),
		.count (upper_count),
		.stat  (upper_stat)
	);

	rms_median u_median (
		.lower_head (lower_stat.head),
		.upper_head (upper_stat.head),
		.odd        (count_s1[0]),
		.median     (median)
	);

	assign count_ext = {{rms_pkg::COUNT_OUT_W{1'b0}}, count_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q      <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				held_q <= last_of_stream ? '0 : (full ? held_q : held_inc[CW-1:0]);
			end
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (s1_adv) begin
				valid_s1 <= 1'b0;
			end
			if (s1_adv) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			count_s1 <= full ? held_q : held_inc[CW-1:0];
			full_s1  <= full;
		end
		if (s1_adv) begin
			median_q <= median;
			count_q  <= count_ext[rms_pkg::COUNT_OUT_W-1:0];
			full_q   <= full_s1;
		end
	end

	assign out_valid    = out_valid_q;
	assign median_value = median_q;
	assign item_count   = count_q;
	assign store_full   = full_q;

endmodule

// ===== hdl/rms_checker.sv =====
// ----------------------------------------------------------------------------
// rms_checker
// Port-level checks of the running median stream block.
// ----------------------------------------------------------------------------
module rms_checker #(
	parameter int MAX_ITEMS = rms_pkg::MAX_ITEMS_DEF
) (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_stall,
	input logic signed [rms_pkg::DATA_W-1:0] sample_value,
	input logic                              last_of_stream,
	input logic                              out_valid,
	input logic                              out_stall,
	input logic signed [rms_pkg::DATA_W-1:0] median_value,
	input logic [rms_pkg::COUNT_OUT_W-1:0]   item_count,
	input logic                              store_full
);

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(sample_value)
			&& $stable(last_of_stream))
		else $error("Input item changed while stalled.");

	a_out_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("Output item withdrawn while stalled.");

	a_out_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(median_value) && $stable(item_count)
			&& $stable(store_full))
		else $error("Output item changed while stalled.");

	a_in_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("Input stalled while the output side is free.");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && store_full |-> item_count == rms_pkg::COUNT_OUT_W'(MAX_ITEMS))
		else $error("Dropped item reports a count other than the capacity.");

endmodule

bind running_median_stream rms_checker #(.MAX_ITEMS(MAX_ITEMS)) u_rms_checker (.*);

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Checks the running median stream block. Each result is compared with the
// median of a sorted model of the held samples, or a typed expectation,
// including the averaged even-count case, a full store and the end-of-stream reset.
// ----------------------------------------------------------------------------
module tb_top;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CAP = rms_pkg::MAX_ITEMS_DEF;
	localparam int RANDOM_ITEMS = 800;

	typedef struct packed {
		logic signed [rms_pkg::DATA_W-1:0]  median;
		logic [rms_pkg::COUNT_OUT_W-1:0]    count;
		logic                               full;
	} median_res_t;

	typedef struct packed {
		logic signed [rms_pkg::DATA_W-1:0]  sample;
		logic                               last;
		logic                               typed;
		median_res_t                        res;
	} sample_row_t;

	logic                               clk = 1'b0;
	logic                               arst_n = 1'b0;
	logic                               in_valid = 1'b0;
	logic                               in_stall;
	logic signed [rms_pkg::DATA_W-1:0]  sample_value = '0;
	logic                               last_of_stream = 1'b0;
	logic                               out_valid;
	logic                               out_stall = 1'b0;
	logic signed [rms_pkg::DATA_W-1:0]  median_value;
	logic [rms_pkg::COUNT_OUT_W-1:0]    item_count;
	logic                               store_full;

	logic signed [rms_pkg::DATA_W-1:0]  held_sorted[$];
	median_res_t                        pending_medians[$];
	sample_row_t                        directed_rows[$];
	bit                                 calm = 1'b0;
	int                                 mismatches = 0;
	int                                 samples_sent = 0;
	int                                 streams_sent = 0;
	int                                 medians_seen = 0;
	int                                 drops_seen = 0;

	running_median_stream #(
		.MAX_ITEMS(CAP)
	) u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.sample_value  (sample_value),
		.last_of_stream(last_of_stream),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.median_value  (median_value),
		.item_count    (item_count),
		.store_full    (store_full)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		#(20_000_000);
		$display("tb_top: FAIL");
		$finish;
	end

	function automatic median_res_t predict_median(
			logic signed [rms_pkg::DATA_W-1:0] v, logic last);
		median_res_t                        r;
		int                                 pos;
		int                                 c;
		logic signed [rms_pkg::DATA_W:0]    lo;
		logic signed [rms_pkg::DATA_W:0]    hi;
		logic signed [rms_pkg::DATA_W:0]    pair_sum;
		r.full = (held_sorted.size() >= CAP);
		if (!r.full) begin
			pos = 0;
			while (pos < held_sorted.size() && held_sorted[pos] <= v)
				pos++;
			held_sorted.insert(pos, v);
		end
		c = held_sorted.size();
		if (c == 0) begin
			r.median = '0;
		end else if (c % 2 == 1) begin
			r.median = held_sorted[c / 2];
		end else begin
			lo = held_sorted[c / 2 - 1];
			hi = held_sorted[c / 2];
			pair_sum = lo + hi;
			pair_sum = pair_sum / 33'sd2;
			r.median = pair_sum[rms_pkg::DATA_W-1:0];
		end
		r.count = c[rms_pkg::COUNT_OUT_W-1:0];
		if (last)
			held_sorted.delete();
		return r;
	endfunction

	function automatic int gap_len();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic logic signed [rms_pkg::DATA_W-1:0] random_sample();
		int r;
		r = $urandom_range(0, 9);
		if (r < 5)
			return $urandom;
		if (r < 8)
			return $urandom_range(0, 40) - 20;
		if (r == 8)
			return $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
		return $urandom & 32'h0000FFFF;
	endfunction

	task automatic add_row(logic signed [rms_pkg::DATA_W-1:0] s, logic last,
			logic typed, logic signed [rms_pkg::DATA_W-1:0] med, int cnt,
			logic full);
		sample_row_t row;
		row.sample = s;
		row.last = last;
		row.typed = typed;
		row.res.median = med;
		row.res.count = cnt[rms_pkg::COUNT_OUT_W-1:0];
		row.res.full = full;
		directed_rows.insert(directed_rows.size(), row);
	endtask

	// The item is driven at the edge where the previous one was taken, or after a gap.
	task automatic feed_sample(logic signed [rms_pkg::DATA_W-1:0] s, logic last,
			logic typed, median_res_t typed_res);
		int          gap;
		median_res_t r;
		gap = gap_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		sample_value <= s;
		last_of_stream <= last;
		do
			@(posedge clk);
		while (in_stall);
		r = predict_median(s, last);
		pending_medians.insert(pending_medians.size(), typed ? typed_res : r);
		samples_sent++;
		if (last)
			streams_sent++;
	endtask

	task automatic drain_pending();
		while (pending_medians.size() != 0)
			@(posedge clk);
	endtask

	always @(posedge clk) begin
		static int   stall_left = 0;
		static logic stall_on = 1'b0;
		median_res_t got;
		median_res_t want;
		int          r;
		if (out_valid && !out_stall) begin
			got.median = median_value;
			got.count = item_count;
			got.full = store_full;
			medians_seen++;
			if (store_full)
				drops_seen++;
			if (pending_medians.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: median %0d count %0d full %0b",
						got.median, got.count, got.full);
			end else begin
				want = pending_medians.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"result %0d: expected median %0d count %0d full %0b,",
							" got median %0d count %0d full %0b"},
							medians_seen, want.median, want.count, want.full,
							got.median, got.count, got.full);
				end
			end
		end
		if (stall_left == 0) begin
			r = $urandom_range(0, 99);
			if (calm || r < 55) begin
				stall_on = 1'b0;
				stall_left = $urandom_range(1, 12);
			end else if (r < 92) begin
				stall_on = 1'b1;
				stall_left = $urandom_range(1, 3);
			end else begin
				stall_on = 1'b1;
				stall_left = $urandom_range(10, 40);
			end
		end
		stall_left--;
		out_stall <= stall_on;
	end

	initial begin
		median_res_t no_res;
		int          sent;
		int          len;
		no_res = '0;

		add_row(32'sh7FFFFFFF, 1'b0, 1'b1, 32'sh7FFFFFFF, 1, 1'b0);
		add_row(32'sh80000000, 1'b0, 1'b1, 32'sh00000000, 2, 1'b0);
		add_row(32'sh80000000, 1'b1, 1'b1, 32'sh80000000, 3, 1'b0);
		add_row(32'sh7FFFFFFF, 1'b0, 1'b1, 32'sh7FFFFFFF, 1, 1'b0);
		add_row(32'sh7FFFFFFF, 1'b0, 1'b1, 32'sh7FFFFFFF, 2, 1'b0);
		add_row(32'sh7FFFFFFE, 1'b1, 1'b1, 32'sh7FFFFFFF, 3, 1'b0);
		add_row(-32'sd1, 1'b0, 1'b1, -32'sd1, 1, 1'b0);
		add_row(-32'sd2, 1'b1, 1'b1, -32'sd1, 2, 1'b0);
		add_row(32'sd0, 1'b1, 1'b1, 32'sd0, 1, 1'b0);
		add_row(32'sd5, 1'b1, 1'b1, 32'sd5, 1, 1'b0);
		add_row(32'sh80000000, 1'b0, 1'b1, 32'sh80000000, 1, 1'b0);
		add_row(32'sh80000000, 1'b0, 1'b1, 32'sh80000000, 2, 1'b0);
		add_row(32'sh80000000, 1'b1, 1'b1, 32'sh80000000, 3, 1'b0);
		add_row(32'shAAAAAAAA, 1'b0, 1'b0, '0, 0, 1'b0);
		add_row(32'sh55555555, 1'b0, 1'b0, '0, 0, 1'b0);
		add_row(32'sd3, 1'b0, 1'b0, '0, 0, 1'b0);
		add_row(32'sd3, 1'b0, 1'b0, '0, 0, 1'b0);
		add_row(-32'sd7, 1'b0, 1'b0, '0, 0, 1'b0);
		add_row(32'sd3, 1'b0, 1'b0, '0, 0, 1'b0);
		add_row(32'sd1, 1'b0, 1'b0, '0, 0, 1'b0);
		add_row(32'sh0000FFFF, 1'b1, 1'b0, '0, 0, 1'b0);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			feed_sample(directed_rows[i].sample, directed_rows[i].last,
				directed_rows[i].typed, directed_rows[i].res);

		// The sender holds off until the block has nothing left in flight.
		in_valid <= 1'b0;
		drain_pending();

		// One stream fills the store, then more samples are dropped; the last
		// of them also ends the stream.
		for (int i = 0; i < CAP + 6; i++)
			feed_sample(random_sample(), i == CAP + 5, 1'b0, no_res);

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			calm = ($urandom_range(0, 99) < 15);
			len = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 24)
				: $urandom_range(40, 160);
			for (int i = 0; i < len; i++)
				feed_sample(random_sample(), i == len - 1, 1'b0, no_res);
			sent += len;
			if ($urandom_range(0, 9) == 0) begin
				in_valid <= 1'b0;
				drain_pending();
			end
		end
		calm = 1'b0;

		in_valid <= 1'b0;
		drain_pending();
		repeat (6) @(posedge clk);

		$display("run: %0d samples in %0d streams, %0d medians checked,",
			samples_sent, streams_sent, medians_seen);
		$display("run: %0d drops on a full store", drops_seen);
		if (mismatches == 0 && pending_medians.size() == 0) begin
			$display("tb_top: PASS");
		end else begin
			$display("run: %0d mismatches", mismatches);
			$display("tb_top: FAIL");
		end
		$finish;
	end

endmodule
